// File: hdl/aat_pkg.sv
// Package for the bounding-box accumulate/transform block.
// Holds the item types, command codes and Q16.16 constants; depends on nothing.
package aat_pkg;

   typedef logic signed [31:0] q_type;

   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_ADD_POINT = 3'd1,
      CMD_LOAD_ROW  = 3'd2,
      CMD_TRANSFORM = 3'd3,
      CMD_SCALE     = 3'd4,
      CMD_ENLARGE   = 3'd5
   } cmd_type;

   localparam int unsigned POSE_ROWS = 3;
   localparam int unsigned POSE_COLS = 4;
   localparam int unsigned PROD_W    = 48;
   localparam int unsigned SUM_W     = 51;

   localparam q_type Q_ZERO = 32'sh0000_0000;
   localparam q_type Q_ONE  = 32'sh0001_0000;

   // Row r, column c at index r*4+c.
   typedef q_type [POSE_ROWS*POSE_COLS-1:0] pose_type;

   localparam pose_type POSE_RESET = {
      Q_ZERO, Q_ONE,  Q_ZERO, Q_ZERO,
      Q_ZERO, Q_ZERO, Q_ONE,  Q_ZERO,
      Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE
   };

   typedef struct packed {
      logic        filled;
      q_type [2:0] low;
      q_type [2:0] high;
   } box_type;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] row_index;
      q_type      value_a;
      q_type      value_b;
      q_type      value_c;
      q_type      value_d;
   } req_type;

   typedef struct packed {
      logic  box_valid;
      q_type low_x;
      q_type low_y;
      q_type low_z;
      q_type high_x;
      q_type high_y;
      q_type high_z;
   } rsp_type;

endpackage

// File: hdl/aabb_accumulate_transform.sv
// 3D axis-aligned bounding box accumulator with a 3x4 Q16.16 pose transform.
// Send one command per item on req_; every item returns exactly one rsp_ item
// with the box as it stands after that command (corners read 0 while empty).
// The block takes one item per clock cycle when rsp_stall is low; an item
// accepted into the input register moves to the result register as soon as
// that register is empty or being drained, and its result then stays on rsp_
// until it is taken. The work of one item is combinational between those
// registers, and the deepest path is the transform: eighteen 32x32 products
// (low and high corner against each non-translation pose entry), per-axis
// min/max, a three-term sum plus translation and one saturation. Because the
// box and pose update as an item moves to the result register, back-to-back
// items that depend on each other (add then transform, load pose then
// transform) need no gaps. Reset restores an empty box and an identity pose
// with zero translation.
// Depends on aat_pkg and aat_update.
module aabb_accumulate_transform (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aat_pkg::rsp_type rsp_payload
);

   // Input register.
   logic             in_valid_ff, in_valid_in;
   aat_pkg::req_type in_item_ff,  in_item_in;

   // Architectural state.
   aat_pkg::box_type  box_ff,  box_in;
   aat_pkg::pose_type pose_ff, pose_in;

   // Result register.
   logic             out_valid_ff, out_valid_in;
   aat_pkg::rsp_type out_item_ff,  out_item_in;

   aat_pkg::box_type  box_calc;
   aat_pkg::pose_type pose_calc;

   logic advance;

   // Move the held item forward whenever the result register is empty or
   // being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   aat_update u_update (
      .item      (in_item_ff),
      .box       (box_ff),
      .pose      (pose_ff),
      .box_next  (box_calc),
      .pose_next (pose_calc)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in = req_payload;
         end
      end
   end

   always_comb begin
      box_in       = box_ff;
      pose_in      = pose_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         box_in       = box_calc;
         pose_in      = pose_calc;
         out_valid_in = 1'b1;
         // Hide the corners of an empty box.
         out_item_in.box_valid = box_calc.filled;
         out_item_in.low_x  = box_calc.filled ? box_calc.low[0]  : aat_pkg::Q_ZERO;
         out_item_in.low_y  = box_calc.filled ? box_calc.low[1]  : aat_pkg::Q_ZERO;
         out_item_in.low_z  = box_calc.filled ? box_calc.low[2]  : aat_pkg::Q_ZERO;
         out_item_in.high_x = box_calc.filled ? box_calc.high[0] : aat_pkg::Q_ZERO;
         out_item_in.high_y = box_calc.filled ? box_calc.high[1] : aat_pkg::Q_ZERO;
         out_item_in.high_z = box_calc.filled ? box_calc.high[2] : aat_pkg::Q_ZERO;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         box_ff       <= '0;
         pose_ff      <= aat_pkg::POSE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         box_ff       <= box_in;
         pose_ff      <= pose_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // An empty box always holds zero corners.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      !box_ff.filled |-> (box_ff.low == '0 && box_ff.high == '0))
      else $error("empty box holds nonzero corners");

   // A stall toward the source only happens with an item held.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a held item");

   // Every advanced item lands in the result register.
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item lost");

   // Clear leaves an empty box.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.command == aat_pkg::CMD_CLEAR) |=> !box_ff.filled)
      else $error("clear did not empty the box");

   // Only add point fills an empty box.
   a_fill_add: assert property (@(posedge clock) disable iff (reset)
      (advance && !box_ff.filled && in_item_ff.command != aat_pkg::CMD_ADD_POINT)
      |=> !box_ff.filled)
      else $error("box filled without a point");

endmodule

// File: hdl/aat_qmul.sv
// Q16.16 multiplier with round-half-up to a 48-bit Q32.16 product, no saturation.
// Depends on aat_pkg.
module aat_qmul (
   input  aat_pkg::q_type                       a,
   input  aat_pkg::q_type                       b,
   output logic signed [aat_pkg::PROD_W-1:0]    p
);

   logic signed [63:0] full;
   logic signed [63:0] rounded;

   assign full    = 64'(a) * 64'(b);
   assign rounded = full + 64'sd32768;
   // Arithmetic floor of the division by 2^16.
   assign p       = rounded[aat_pkg::PROD_W+15:16];

endmodule

// File: hdl/aat_update.sv
// Next-state logic for box and pose: min/max, products, sums, saturation.
// Depends on aat_pkg and aat_qmul.
module aat_update (
   input  aat_pkg::req_type  item,
   input  aat_pkg::box_type  box,
   input  aat_pkg::pose_type pose,
   output aat_pkg::box_type  box_next,
   output aat_pkg::pose_type pose_next
);

   localparam int unsigned SW = aat_pkg::SUM_W;
   localparam logic signed [aat_pkg::SUM_W-1:0] SAT_HI = 51'sd2147483647;
   localparam logic signed [aat_pkg::SUM_W-1:0] SAT_LO = -51'sd2147483648;

   function automatic aat_pkg::q_type sat_q(input logic signed [aat_pkg::SUM_W-1:0] v);
      if (v > SAT_HI) begin
         return 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   aat_pkg::q_type vin [3];
   assign vin[0] = item.value_a;
   assign vin[1] = item.value_b;
   assign vin[2] = item.value_c;

   logic is_scale;
   assign is_scale = (item.command == aat_pkg::CMD_SCALE);

   // Product pairs: row r times low/high of axis c. Diagonal pairs double as the
   // scale multipliers.
   logic signed [aat_pkg::PROD_W-1:0] prod_lo [3][3];
   logic signed [aat_pkg::PROD_W-1:0] prod_hi [3][3];
   logic signed [aat_pkg::PROD_W-1:0] pmin    [3][3];
   logic signed [aat_pkg::PROD_W-1:0] pmax    [3][3];

   aat_pkg::q_type xf_low  [3];
   aat_pkg::q_type xf_high [3];
   aat_pkg::q_type sc_low  [3];
   aat_pkg::q_type sc_high [3];
   aat_pkg::q_type en_low  [3];
   aat_pkg::q_type en_high [3];
   aat_pkg::q_type ad_low  [3];
   aat_pkg::q_type ad_high [3];

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [aat_pkg::SUM_W-1:0] sum_min;
      logic signed [aat_pkg::SUM_W-1:0] sum_max;
      for (genvar c = 0; c < 3; c++) begin : g_col
         aat_pkg::q_type coef;
         if (r == c) begin : g_diag
            assign coef = is_scale ? vin[c] : pose[r*4+c];
         end else begin : g_off
            assign coef = pose[r*4+c];
         end
         aat_qmul u_mul_lo (.a(coef), .b(box.low[c]),  .p(prod_lo[r][c]));
         aat_qmul u_mul_hi (.a(coef), .b(box.high[c]), .p(prod_hi[r][c]));
         assign pmin[r][c] = (prod_lo[r][c] < prod_hi[r][c]) ? prod_lo[r][c] : prod_hi[r][c];
         assign pmax[r][c] = (prod_lo[r][c] < prod_hi[r][c]) ? prod_hi[r][c] : prod_lo[r][c];
      end
      // Corner choice is independent per axis, so the extreme corner sum is the
      // sum of per-axis extremes; saturation is monotonic.
      assign sum_min = SW'(pmin[r][0]) + SW'(pmin[r][1]) + SW'(pmin[r][2])
                       + SW'(pose[r*4+3]);
      assign sum_max = SW'(pmax[r][0]) + SW'(pmax[r][1]) + SW'(pmax[r][2])
                       + SW'(pose[r*4+3]);
      assign xf_low[r]  = sat_q(sum_min);
      assign xf_high[r] = sat_q(sum_max);
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [aat_pkg::SUM_W-1:0] s_lo;
      logic signed [aat_pkg::SUM_W-1:0] s_hi;
      logic signed [aat_pkg::SUM_W-1:0] e_lo;
      logic signed [aat_pkg::SUM_W-1:0] e_hi;
      assign s_lo = SW'(prod_lo[i][i]);
      assign s_hi = SW'(prod_hi[i][i]);
      assign sc_low[i]  = sat_q(s_lo);
      assign sc_high[i] = sat_q(s_hi);
      assign e_lo = SW'($signed(box.low[i]))  - SW'(vin[i]);
      assign e_hi = SW'($signed(box.high[i])) + SW'(vin[i]);
      assign en_low[i]  = sat_q(e_lo);
      assign en_high[i] = sat_q(e_hi);
      assign ad_low[i]  = (!box.filled || (vin[i] < $signed(box.low[i])))
                          ? vin[i] : box.low[i];
      assign ad_high[i] = (!box.filled || (vin[i] > $signed(box.high[i])))
                          ? vin[i] : box.high[i];
   end

   always_comb begin
      box_next  = box;
      pose_next = pose;
      unique case (item.command)
         aat_pkg::CMD_CLEAR: begin
            box_next = '0;
         end
         aat_pkg::CMD_ADD_POINT: begin
            box_next.filled = 1'b1;
            for (int i = 0; i < 3; i++) begin
               box_next.low[i]  = ad_low[i];
               box_next.high[i] = ad_high[i];
            end
         end
         aat_pkg::CMD_LOAD_ROW: begin
            // Row index three drops the write.
            for (int r = 0; r < 3; r++) begin
               if (item.row_index == 2'(r)) begin
                  pose_next[r*4+0] = item.value_a;
                  pose_next[r*4+1] = item.value_b;
                  pose_next[r*4+2] = item.value_c;
                  pose_next[r*4+3] = item.value_d;
               end
            end
         end
         aat_pkg::CMD_TRANSFORM: begin
            if (box.filled) begin
               for (int i = 0; i < 3; i++) begin
                  box_next.low[i]  = xf_low[i];
                  box_next.high[i] = xf_high[i];
               end
            end
         end
         aat_pkg::CMD_SCALE: begin
            if (box.filled) begin
               for (int i = 0; i < 3; i++) begin
                  box_next.low[i]  = sc_low[i];
                  box_next.high[i] = sc_high[i];
               end
            end
         end
         aat_pkg::CMD_ENLARGE: begin
            if (box.filled) begin
               for (int i = 0; i < 3; i++) begin
                  box_next.low[i]  = en_low[i];
                  box_next.high[i] = en_high[i];
               end
            end
         end
         default: begin
            box_next  = box;
         end
      endcase
   end

endmodule

// File: tb/aabb_box_checker.sv
// In-order scoreboard for the bounding-box accumulate/transform block.
// Holds its own box and pose, predicts one result per accepted item and
// compares every result field by field. Depends on aat_pkg.
module aabb_box_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  aat_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  aat_pkg::rsp_type rsp_payload,
   output int unsigned      boxes_pending,
   output int unsigned      mismatches
);

   localparam aat_pkg::q_type Q_MAX = 32'sh7FFF_FFFF;
   localparam aat_pkg::q_type Q_MIN = 32'sh8000_0000;

   aat_pkg::q_type  box_low [3];
   aat_pkg::q_type  box_high [3];
   logic            box_filled;
   aat_pkg::q_type  pose [aat_pkg::POSE_ROWS*aat_pkg::POSE_COLS];
   aat_pkg::rsp_type expected_boxes [$];
   int unsigned     error_total = 0;
   int unsigned     boxes_seen = 0;

   assign mismatches = error_total;

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", boxes_seen, msg);
      error_total++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   function automatic aat_pkg::q_type clamp_q(input longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return aat_pkg::q_type'(v);
   endfunction

   // Q16.16 product rounded half up; the shift floors for negative sums too.
   function automatic longint round_mul(input aat_pkg::q_type a, input aat_pkg::q_type b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return p >>> 16;
   endfunction

   function automatic void clear_predictor();
      int i;
      for (i = 0; i < 3; i++) begin
         box_low[i]  = aat_pkg::Q_ZERO;
         box_high[i] = aat_pkg::Q_ZERO;
      end
      box_filled = 1'b0;
      for (i = 0; i < aat_pkg::POSE_ROWS*aat_pkg::POSE_COLS; i++) begin
         pose[i] = (i % (aat_pkg::POSE_COLS + 1) == 0) ? aat_pkg::Q_ONE : aat_pkg::Q_ZERO;
      end
   endfunction

   // Apply one command to the predicted state and return the box after it.
   function automatic aat_pkg::rsp_type next_box(input aat_pkg::req_type item);
      aat_pkg::q_type   v [4];
      aat_pkg::q_type   corner [3];
      aat_pkg::q_type   new_low [3];
      aat_pkg::q_type   new_high [3];
      aat_pkg::q_type   mapped;
      longint           sum;
      int               i;
      int               k;
      int               row;
      aat_pkg::rsp_type box;
      v[0] = item.value_a;
      v[1] = item.value_b;
      v[2] = item.value_c;
      v[3] = item.value_d;
      row  = int'(item.row_index);
      case (item.command)
         aat_pkg::CMD_CLEAR: begin
            for (i = 0; i < 3; i++) begin
               box_low[i]  = aat_pkg::Q_ZERO;
               box_high[i] = aat_pkg::Q_ZERO;
            end
            box_filled = 1'b0;
         end
         aat_pkg::CMD_ADD_POINT: begin
            for (i = 0; i < 3; i++) begin
               if (!box_filled || v[i] < box_low[i]) box_low[i] = v[i];
               if (!box_filled || v[i] > box_high[i]) box_high[i] = v[i];
            end
            box_filled = 1'b1;
         end
         aat_pkg::CMD_LOAD_ROW: begin
            if (row < aat_pkg::POSE_ROWS) begin
               for (i = 0; i < aat_pkg::POSE_COLS; i++) begin
                  pose[row*aat_pkg::POSE_COLS + i] = v[i];
               end
            end
         end
         aat_pkg::CMD_TRANSFORM: begin
            if (box_filled) begin
               for (k = 0; k < 8; k++) begin
                  corner[0] = k[0] ? box_high[0] : box_low[0];
                  corner[1] = k[1] ? box_high[1] : box_low[1];
                  corner[2] = k[2] ? box_high[2] : box_low[2];
                  for (i = 0; i < 3; i++) begin
                     sum = round_mul(pose[i*aat_pkg::POSE_COLS], corner[0])
                         + round_mul(pose[i*aat_pkg::POSE_COLS + 1], corner[1])
                         + round_mul(pose[i*aat_pkg::POSE_COLS + 2], corner[2])
                         + longint'(pose[i*aat_pkg::POSE_COLS + 3]);
                     mapped = clamp_q(sum);
                     if (k == 0 || mapped < new_low[i]) new_low[i] = mapped;
                     if (k == 0 || mapped > new_high[i]) new_high[i] = mapped;
                  end
               end
               for (i = 0; i < 3; i++) begin
                  box_low[i]  = new_low[i];
                  box_high[i] = new_high[i];
               end
            end
         end
         aat_pkg::CMD_SCALE: begin
            if (box_filled) begin
               for (i = 0; i < 3; i++) begin
                  box_low[i]  = clamp_q(round_mul(box_low[i], v[i]));
                  box_high[i] = clamp_q(round_mul(box_high[i], v[i]));
               end
            end
         end
         aat_pkg::CMD_ENLARGE: begin
            if (box_filled) begin
               for (i = 0; i < 3; i++) begin
                  box_low[i]  = clamp_q(longint'(box_low[i]) - longint'(v[i]));
                  box_high[i] = clamp_q(longint'(box_high[i]) + longint'(v[i]));
               end
            end
         end
         default: begin
         end
      endcase
      box.box_valid = box_filled;
      box.low_x     = box_filled ? box_low[0]  : aat_pkg::Q_ZERO;
      box.low_y     = box_filled ? box_low[1]  : aat_pkg::Q_ZERO;
      box.low_z     = box_filled ? box_low[2]  : aat_pkg::Q_ZERO;
      box.high_x    = box_filled ? box_high[0] : aat_pkg::Q_ZERO;
      box.high_y    = box_filled ? box_high[1] : aat_pkg::Q_ZERO;
      box.high_z    = box_filled ? box_high[2] : aat_pkg::Q_ZERO;
      return box;
   endfunction

   always @(posedge clock) begin : watch
      aat_pkg::rsp_type want;
      if (reset) begin
         clear_predictor();
         expected_boxes.delete();
         boxes_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_boxes.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_boxes.pop_front();
               check_field("box_valid", 32'(rsp_payload.box_valid), 32'(want.box_valid));
               check_field("low_x",  rsp_payload.low_x,  want.low_x);
               check_field("low_y",  rsp_payload.low_y,  want.low_y);
               check_field("low_z",  rsp_payload.low_z,  want.low_z);
               check_field("high_x", rsp_payload.high_x, want.high_x);
               check_field("high_y", rsp_payload.high_y, want.high_y);
               check_field("high_z", rsp_payload.high_z, want.high_z);
            end
            boxes_seen++;
         end
         if (req_valid && !req_stall) begin
            expected_boxes.insert(expected_boxes.size(), next_box(req_payload));
         end
         boxes_pending <= expected_boxes.size();
      end
   end

endmodule

// File: tb/aabb_accumulate_transform_tb.sv
// Top of the bounding-box accumulate/transform testbench: clock, reset,
// stimulus with random idling on both channels, and the verdict.
// Depends on aat_pkg, aabb_box_checker and the block itself.
module aabb_accumulate_transform_tb;

   // Codes the block must ignore, and the pose row that does not exist.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam logic [1:0] ROW_NONE    = 2'd3;

   localparam aat_pkg::q_type Q_ZERO = aat_pkg::Q_ZERO;
   localparam aat_pkg::q_type Q_ONE  = aat_pkg::Q_ONE;
   localparam aat_pkg::q_type Q_MAX  = 32'sh7FFF_FFFF;
   localparam aat_pkg::q_type Q_MIN  = 32'sh8000_0000;
   localparam aat_pkg::q_type Q_HALF = 32'sh0000_8000;

   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned CALM_ITEMS   = 120;
   localparam int unsigned POINT_SPREAD = 1 << 22;
   localparam int unsigned POSE_SPREAD  = 1 << 17;
   localparam int unsigned MARGIN_SPREAD = 1 << 18;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   aat_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   aat_pkg::rsp_type rsp_payload;
   int unsigned      boxes_pending;
   int unsigned      mismatches;
   bit               idling_on = 1'b1;

   always #6 clock = ~clock;

   aabb_accumulate_transform u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   aabb_box_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .boxes_pending (boxes_pending),
      .mismatches    (mismatches)
   );

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #(12 * 200000);
      $display("tb: failure");
      $finish;
   end

   // Receiver: stall the result channel in random bursts of random length.
   // Each burst is followed by stall low before the next one can start.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one item and hold it until the block takes it.
   task automatic send_item(input aat_pkg::req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_cmd(input logic [2:0] command, input logic [1:0] row,
                           input aat_pkg::q_type a, input aat_pkg::q_type b,
                           input aat_pkg::q_type c, input aat_pkg::q_type d);
      aat_pkg::req_type item;
      item.command   = command;
      item.row_index = row;
      item.value_a   = a;
      item.value_b   = b;
      item.value_c   = c;
      item.value_d   = d;
      send_item(item);
   endtask

   // Drop valid for a gap; the payload holds its last value.
   task automatic hold_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   // The first edge lets the pending count catch the last accepted item.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (boxes_pending != 0) @(posedge clock);
   endtask

   // Mostly values near the working range, sometimes any 32 bits or an extreme.
   function automatic aat_pkg::q_type pick_value(input int unsigned spread);
      aat_pkg::q_type v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0:       v = Q_MIN;
               1:       v = Q_MAX;
               2:       v = Q_ZERO;
               3:       v = -32'sd1;
               4:       v = 32'sd1;
               default: v = Q_ONE;
            endcase
         end
         1, 2:    v = aat_pkg::q_type'($urandom);
         default: v = aat_pkg::q_type'(int'($urandom_range(0, 2 * spread)) - int'(spread));
      endcase
      return v;
   endfunction

   // Weighted command mix: point runs dominate, with pose loads and transforms
   // often enough to chain them, and an occasional clear to leave saturation.
   function automatic aat_pkg::req_type random_item();
      aat_pkg::req_type item;
      int unsigned      pick;
      int unsigned      spread;
      pick           = $urandom_range(0, 99);
      spread         = POINT_SPREAD;
      item.row_index = 2'($urandom_range(0, 3));
      if (pick < 6) begin
         item.command = aat_pkg::CMD_CLEAR;
      end else if (pick < 40) begin
         item.command = aat_pkg::CMD_ADD_POINT;
      end else if (pick < 55) begin
         item.command   = aat_pkg::CMD_LOAD_ROW;
         item.row_index = ($urandom_range(0, 11) == 0) ? ROW_NONE
                                                       : 2'($urandom_range(0, 2));
         spread         = POSE_SPREAD;
      end else if (pick < 70) begin
         item.command = aat_pkg::CMD_TRANSFORM;
      end else if (pick < 80) begin
         item.command = aat_pkg::CMD_SCALE;
         spread       = POSE_SPREAD;
      end else if (pick < 92) begin
         item.command = aat_pkg::CMD_ENLARGE;
         spread       = MARGIN_SPREAD;
      end else if (pick < 96) begin
         item.command = CMD_SPARE_6;
      end else begin
         item.command = CMD_SPARE_7;
      end
      item.value_a = pick_value(spread);
      item.value_b = pick_value(spread);
      item.value_c = pick_value(spread);
      item.value_d = pick_value(POINT_SPREAD);
      return item;
   endfunction

   initial begin : stimulus
      int unsigned n;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty box: transform, scale and enlarge must leave it empty.
      send_cmd(aat_pkg::CMD_TRANSFORM, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_SCALE, 2'd1, Q_MIN, Q_MAX, -32'sd1, Q_MAX);
      send_cmd(aat_pkg::CMD_ENLARGE, 2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MIN);

      // First point starts the box, second stretches it to the full range in x and y.
      send_cmd(aat_pkg::CMD_ADD_POINT, 2'd0, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_ADD_POINT, 2'd3, Q_MAX, Q_MIN, -32'sd1, Q_MAX);

      // Enlarge a full-range box to force saturation on both corners.
      send_cmd(aat_pkg::CMD_ENLARGE, 2'd0, Q_ONE, Q_ONE, Q_ONE, Q_ZERO);
      send_cmd(aat_pkg::CMD_TRANSFORM, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);

      // Unknown codes and a pose row that does not exist change nothing.
      send_cmd(CMD_SPARE_6, 2'd1, Q_MAX, Q_MIN, Q_ONE, Q_MAX);
      send_cmd(CMD_SPARE_7, 2'd2, Q_MIN, Q_MAX, -Q_ONE, Q_MIN);
      send_cmd(aat_pkg::CMD_LOAD_ROW, ROW_NONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN);

      // Rounding: halves go toward plus infinity, so 1 * 0.5 -> 1, -1 * 0.5 -> 0.
      send_cmd(aat_pkg::CMD_CLEAR, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_ADD_POINT, 2'd0, 32'sd1, -32'sd1, 32'sd3, Q_ZERO);
      send_cmd(aat_pkg::CMD_SCALE, 2'd0, Q_HALF, Q_HALF, Q_HALF, Q_ZERO);

      // Negative scale and margin: corners are not swapped.
      send_cmd(aat_pkg::CMD_ADD_POINT, 2'd0, Q_ONE, -Q_ONE, Q_ONE * 2, Q_ZERO);
      send_cmd(aat_pkg::CMD_SCALE, 2'd0, -Q_ONE, Q_ONE * 2, -Q_HALF, Q_ZERO);
      send_cmd(aat_pkg::CMD_ENLARGE, 2'd0, -Q_ONE, Q_HALF, -32'sd1, Q_ZERO);

      // Quarter turn about z with translation, applied straight after the load.
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd0, Q_ZERO, -Q_ONE, Q_ZERO, Q_ONE * 5);
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd1, Q_ONE, Q_ZERO, Q_ZERO, -Q_ONE);
      send_cmd(aat_pkg::CMD_TRANSFORM, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);

      // Extreme pose entries: sums far outside 32 bits must saturate.
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd2, Q_MAX, Q_MIN, Q_ONE, Q_MIN);
      send_cmd(aat_pkg::CMD_TRANSFORM, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_SCALE, 2'd0, Q_MAX, Q_MIN, Q_MAX, Q_ZERO);

      // Clear keeps the pose; a transform on the empty box stays empty.
      send_cmd(aat_pkg::CMD_CLEAR, 2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_cmd(aat_pkg::CMD_TRANSFORM, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);

      // Restore identity before the random part.
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd1, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
      send_cmd(aat_pkg::CMD_LOAD_ROW, 2'd2, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO);

      // Random part; idling stops for the last stretch, and halfway through
      // the sender waits for the block to run completely dry.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) idling_on <= 1'b0;
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            hold_sender($urandom_range(1, 16));
         end
         send_item(random_item());
      end

      // Wait for the last results, then give the verdict.
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && boxes_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/aat_pkg.sv
hdl/aat_qmul.sv
hdl/aat_update.sv
hdl/aabb_accumulate_transform.sv
tb/aabb_box_checker.sv
tb/aabb_accumulate_transform_tb.sv
